// ----- hw/rtl/kmeg_pkg.sv -----
// Shared types, register codes and constants of the key matrix event generator.
package kmeg_pkg;

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    // Register indexes, taken from paddr[5:3].
    localparam logic [2:0] REG_PRESENT     = 3'd0;
    localparam logic [2:0] REG_REPEAT      = 3'd1;
    localparam logic [2:0] REG_HOLD        = 3'd2;
    localparam logic [2:0] REG_LONG        = 3'd3;
    localparam logic [2:0] REG_FIRST_PAUSE = 3'd4;
    localparam logic [2:0] REG_MIN_PAUSE   = 3'd5;

    localparam logic [47:0] PRESENT_RST     = 48'd69497663782902;
    localparam logic [47:0] REPEAT_RST      = 48'd13332116178100;
    localparam logic [15:0] HOLD_RST        = 16'd100;
    localparam logic [15:0] LONG_RST        = 16'd500;
    localparam logic [15:0] FIRST_PAUSE_RST = 16'd100;
    localparam logic [15:0] MIN_PAUSE_RST   = 16'd10;

    // floor(p * 10 / 11) is taken as (p * PAUSE_RECIP) >> PAUSE_SHIFT.
    // PAUSE_RECIP is 10 * ceil(2^24 / 11); exact for every 16-bit p.
    localparam logic [23:0] PAUSE_RECIP = 24'd15252020;
    localparam int          PAUSE_SHIFT = 24;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_REPEAT  = 2'd1,
        EV_LONG    = 2'd2,
        EV_RELEASE = 2'd3
    } ev_kind_t;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
        ev_kind_t   kind;
    } ev_t;

    typedef struct packed {
        logic [47:0] present_mask;
        logic [47:0] repeat_mask;
        logic [15:0] hold_ms;
        logic [15:0] long_ms;
        logic [15:0] first_pause;
        logic [15:0] min_pause;
    } cfg_t;

    typedef struct packed {
        logic ready;
        logic pend_valid;
    } evq_stat_t;

    // Bit row*8+column of a 48-bit mask; positions past bit 47 read as clear.
    function automatic logic mask_bit(logic [47:0] m, logic [2:0] row, logic [2:0] col);
        logic [5:0] idx;
        idx = {row, col};
        mask_bit = (idx < 6'd48) ? m[idx] : 1'b0;
    endfunction

endpackage

// ----- hw/rtl/kmeg_cfg.sv -----
// Configuration register file with its APB-style write and read port.
module kmeg_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kmeg_pkg::ADDR_W-1:0]  paddr,
    input  logic [kmeg_pkg::DATA_W-1:0]  pwdata,
    output logic [kmeg_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output kmeg_pkg::cfg_t               cfg
);

    kmeg_pkg::cfg_t cfg_reg;
    kmeg_pkg::cfg_t cfg_next;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                kmeg_pkg::REG_PRESENT:     cfg_next.present_mask = pwdata[47:0];
                kmeg_pkg::REG_REPEAT:      cfg_next.repeat_mask  = pwdata[47:0];
                kmeg_pkg::REG_HOLD:        cfg_next.hold_ms      = pwdata[15:0];
                kmeg_pkg::REG_LONG:        cfg_next.long_ms      = pwdata[15:0];
                kmeg_pkg::REG_FIRST_PAUSE: cfg_next.first_pause  = pwdata[15:0];
                kmeg_pkg::REG_MIN_PAUSE:   cfg_next.min_pause    = pwdata[15:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            kmeg_pkg::REG_PRESENT:     prdata = {16'd0, cfg_reg.present_mask};
            kmeg_pkg::REG_REPEAT:      prdata = {16'd0, cfg_reg.repeat_mask};
            kmeg_pkg::REG_HOLD:        prdata = {48'd0, cfg_reg.hold_ms};
            kmeg_pkg::REG_LONG:        prdata = {48'd0, cfg_reg.long_ms};
            kmeg_pkg::REG_FIRST_PAUSE: prdata = {48'd0, cfg_reg.first_pause};
            kmeg_pkg::REG_MIN_PAUSE:   prdata = {48'd0, cfg_reg.min_pause};
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.present_mask <= kmeg_pkg::PRESENT_RST;
            cfg_reg.repeat_mask  <= kmeg_pkg::REPEAT_RST;
            cfg_reg.hold_ms      <= kmeg_pkg::HOLD_RST;
            cfg_reg.long_ms      <= kmeg_pkg::LONG_RST;
            cfg_reg.first_pause  <= kmeg_pkg::FIRST_PAUSE_RST;
            cfg_reg.min_pause    <= kmeg_pkg::MIN_PAUSE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hw/rtl/kmeg_tcmp.sv -----
// Shared elapsed-time comparator: (now - base) modulo 2^32 against a 16-bit limit.
module kmeg_tcmp (
    input  logic [31:0] now_ms,
    input  logic [31:0] base,
    input  logic [15:0] limit,
    output logic        gt
);

    logic [31:0] elapsed;

    assign elapsed = now_ms - base;
    assign gt      = elapsed > {16'd0, limit};

endmodule

// ----- hw/rtl/kmeg_evq.sv -----
// Event holding stage and output register; marks the final event of a scan.
module kmeg_evq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 flush,
    input  kmeg_pkg::ev_t        ev_in,
    output kmeg_pkg::evq_stat_t  stat,
    output logic                 event_valid,
    input  logic                 event_stall,
    output logic [2:0]           key_row,
    output logic [2:0]           key_column,
    output logic [1:0]           event_kind,
    output logic                 last_event
);

    logic          pend_valid_reg;
    logic          pend_valid_next;
    kmeg_pkg::ev_t pend_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    kmeg_pkg::ev_t out_ev_reg;
    logic          out_last_reg;
    logic          out_free;
    logic          ready;
    logic          load_out;
    logic          load_pend;

    // The event held back is only sent once it is known whether another follows.
    assign out_free  = !out_valid_reg || !event_stall;
    assign ready     = !pend_valid_reg || out_free;
    assign load_out  = (push || flush) && pend_valid_reg && out_free;
    assign load_pend = push && ready;

    assign stat.ready      = ready;
    assign stat.pend_valid = pend_valid_reg;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (load_pend)
        begin
            pend_valid_next = 1'b1;
        end
        else if (load_out)
        begin
            pend_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!event_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_pend)
        begin
            pend_reg <= ev_in;
        end
        if (load_out)
        begin
            out_ev_reg   <= pend_reg;
            out_last_reg <= flush;
        end
    end

    assign event_valid = out_valid_reg;
    assign key_row     = out_ev_reg.row;
    assign key_column  = out_ev_reg.col;
    assign event_kind  = out_ev_reg.kind;
    assign last_event  = out_last_reg;

endmodule

// ----- hw/rtl/key_matrix_event_generator_core.sv -----
// Top level of the key matrix event generator: scan sequencer, key state and stamp memory.
// Per key: an absent key passes S_READ only, a present key S_READ and S_EVAL; a long or
// repeat check adds S_CMP2, a pause update S_MUL and S_CLAMP, and an event S_EMIT.
// S_FLUSH ends the walk; an event waits for the next one of its scan or the flush.
// Throughput: one scan per walk, as a scan is taken only in S_IDLE; the walk's length is
// set by the single-port stamp memory and the one shared comparator.
// Reset: configuration returns to its defaults; all keys read released, no long sent.
module key_matrix_event_generator_core #(
    parameter int ROWS    = 6,
    parameter int COLUMNS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kmeg_pkg::ADDR_W-1:0]  paddr,
    input  logic [kmeg_pkg::DATA_W-1:0]  pwdata,
    output logic [kmeg_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         scan_valid,
    output logic                         scan_stall,
    input  logic [31:0]                  now_ms,
    input  logic [47:0]                  pressed_bits,
    output logic                         event_valid,
    input  logic                         event_stall,
    output logic [2:0]                   key_row,
    output logic [2:0]                   key_column,
    output logic [1:0]                   event_kind,
    output logic                         last_event
);

    localparam int NKEYS = ROWS * COLUMNS;
    localparam int KW    = (NKEYS > 1) ? $clog2(NKEYS) : 1;
    localparam logic [2:0] ROW_LAST = 3'(ROWS - 1);
    localparam logic [2:0] COL_LAST = 3'(COLUMNS - 1);

    // One-hot sequencer states.
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_READ  = 8'b0000_0010,
        S_EVAL  = 8'b0000_0100,
        S_CMP2  = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_CLAMP = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_FLUSH = 8'b1000_0000
    } state_t;

    kmeg_pkg::cfg_t      cfg;
    kmeg_pkg::evq_stat_t evq_stat;

    state_t             state_reg, state_next;
    logic [2:0]         row_reg, row_next;
    logic [2:0]         col_reg, col_next;
    logic [KW-1:0]      s_reg, s_next;
    logic [31:0]        now_reg;
    logic [47:0]        pressed_reg;
    logic [NKEYS-1:0]   held_reg, held_next;
    logic [NKEYS-1:0]   long_sent_reg, long_sent_next;
    logic               busy_reg, busy_next;
    logic [31:0]        anchor_reg, anchor_next;
    logic [15:0]        pause_reg, pause_next;
    logic               mode_rep_reg, mode_rep_next;
    kmeg_pkg::ev_t      ev_reg, ev_next;
    logic [39:0]        prod_reg;
    logic [31:0]        stamp_rd_reg;
    logic [31:0]        stamp_mem [NKEYS];

    logic               scan_take;
    logic               stamp_we;
    logic               evq_push;
    logic               evq_flush;
    logic               last_key;
    logic               present;
    logic               down;
    logic               repeatable;
    logic               key_held;
    logic               key_long;
    logic [31:0]        cmp_base;
    logic [15:0]        cmp_limit;
    logic               cmp_gt;
    logic [15:0]        shrunk;

    kmeg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The one comparator serves the hold check, the long check and the repeat pacing.
    kmeg_tcmp u_tcmp (
        .now_ms (now_reg),
        .base   (cmp_base),
        .limit  (cmp_limit),
        .gt     (cmp_gt)
    );

    kmeg_evq u_evq (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (evq_push),
        .flush       (evq_flush),
        .ev_in       (ev_reg),
        .stat        (evq_stat),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .key_row     (key_row),
        .key_column  (key_column),
        .event_kind  (event_kind),
        .last_event  (last_event)
    );

    assign scan_stall = (state_reg != S_IDLE);
    assign scan_take  = scan_valid && !scan_stall;

    // Per-key view of the position that the walk currently points at.
    assign present    = kmeg_pkg::mask_bit(cfg.present_mask, row_reg, col_reg);
    assign down       = kmeg_pkg::mask_bit(pressed_reg, row_reg, col_reg);
    assign repeatable = kmeg_pkg::mask_bit(cfg.repeat_mask, row_reg, col_reg);
    assign key_held   = held_reg[s_reg];
    assign key_long   = long_sent_reg[s_reg];
    assign last_key   = (row_reg == ROW_LAST) && (col_reg == COL_LAST);

    // In the second check the repeat timer or the long threshold is compared.
    always_comb
    begin
        if (state_reg == S_CMP2 && mode_rep_reg)
        begin
            cmp_base  = anchor_reg;
            cmp_limit = pause_reg;
        end
        else if (state_reg == S_CMP2)
        begin
            cmp_base  = stamp_rd_reg;
            cmp_limit = cfg.long_ms;
        end
        else
        begin
            cmp_base  = stamp_rd_reg;
            cmp_limit = cfg.hold_ms;
        end
    end

    // The product never exceeds 16 bits after the shift since p*10/11 < p.
    assign shrunk = prod_reg[kmeg_pkg::PAUSE_SHIFT +: 16];

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        s_next         = s_reg;
        held_next      = held_reg;
        long_sent_next = long_sent_reg;
        busy_next      = busy_reg;
        anchor_next    = anchor_reg;
        pause_next     = pause_reg;
        mode_rep_next  = mode_rep_reg;
        ev_next        = ev_reg;
        stamp_we       = 1'b0;
        evq_push       = 1'b0;
        evq_flush      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (scan_take)
                begin
                    row_next   = 3'd0;
                    col_next   = 3'd0;
                    s_next     = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // Absent positions are passed over without leaving S_READ.
                if (present)
                begin
                    state_next = S_EVAL;
                end
                else
                begin
                    state_next = last_key ? S_FLUSH : S_READ;
                end
            end
            S_EVAL:
            begin
                ev_next.row = row_reg;
                ev_next.col = col_reg;
                state_next  = last_key ? S_FLUSH : S_READ;
                if (!key_held)
                begin
                    if (down && !key_long)
                    begin
                        held_next[s_reg] = 1'b1;
                        stamp_we         = 1'b1;
                        busy_next        = 1'b0;
                        ev_next.kind     = kmeg_pkg::EV_PRESS;
                        state_next       = S_EMIT;
                    end
                end
                else if (cmp_gt)
                begin
                    if (!down)
                    begin
                        held_next[s_reg]      = 1'b0;
                        long_sent_next[s_reg] = 1'b0;
                        busy_next             = 1'b0;
                        if (!key_long)
                        begin
                            ev_next.kind = kmeg_pkg::EV_RELEASE;
                            state_next   = S_EMIT;
                        end
                    end
                    else if (repeatable && !key_long)
                    begin
                        // A timer that is only now started cannot have run out yet.
                        if (!busy_reg)
                        begin
                            busy_next   = 1'b1;
                            anchor_next = now_reg;
                            pause_next  = cfg.first_pause;
                        end
                        else
                        begin
                            mode_rep_next = 1'b1;
                            state_next    = S_CMP2;
                        end
                    end
                    else if (!key_long)
                    begin
                        mode_rep_next = 1'b0;
                        state_next    = S_CMP2;
                    end
                end
            end
            S_CMP2:
            begin
                state_next = last_key ? S_FLUSH : S_READ;
                if (cmp_gt && mode_rep_reg)
                begin
                    anchor_next  = now_reg;
                    ev_next.kind = kmeg_pkg::EV_REPEAT;
                    state_next   = S_MUL;
                end
                else if (cmp_gt)
                begin
                    long_sent_next[s_reg] = 1'b1;
                    ev_next.kind          = kmeg_pkg::EV_LONG;
                    state_next            = S_EMIT;
                end
            end
            S_MUL:
            begin
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                pause_next = (shrunk < cfg.min_pause) ? cfg.min_pause : shrunk;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                evq_push = 1'b1;
                if (evq_stat.ready)
                begin
                    state_next = last_key ? S_FLUSH : S_READ;
                end
            end
            S_FLUSH:
            begin
                evq_flush = 1'b1;
                if (evq_stat.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Step to the next position, column by column with rows inside.
        if (state_reg != S_IDLE && state_reg != S_FLUSH
            && state_next != S_FLUSH && state_next == S_READ && !last_key
            && !(state_reg == S_READ && present))
        begin
            if (row_reg == ROW_LAST)
            begin
                row_next = 3'd0;
                col_next = col_reg + 3'd1;
                s_next   = KW'(col_reg + 3'd1);
            end
            else
            begin
                row_next = row_reg + 3'd1;
                s_next   = s_reg + KW'(COLUMNS);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= 3'd0;
            col_reg       <= 3'd0;
            s_reg         <= '0;
            held_reg      <= '0;
            long_sent_reg <= '0;
            busy_reg      <= 1'b0;
            anchor_reg    <= '0;
            pause_reg     <= '0;
            mode_rep_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            s_reg         <= s_next;
            held_reg      <= held_next;
            long_sent_reg <= long_sent_next;
            busy_reg      <= busy_next;
            anchor_reg    <= anchor_next;
            pause_reg     <= pause_next;
            mode_rep_reg  <= mode_rep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_take)
        begin
            now_reg     <= now_ms;
            pressed_reg <= pressed_bits;
        end
        ev_reg   <= ev_next;
        prod_reg <= pause_reg * kmeg_pkg::PAUSE_RECIP;
    end

    // Press time stamps; a stamp is read at every position but used only while its key is held.
    always_ff @(posedge clk)
    begin
        if (stamp_we)
        begin
            stamp_mem[s_reg] <= now_reg;
        end
        stamp_rd_reg <= stamp_mem[s_reg];
    end

    a_long_implies_held: assert property (@(posedge clk) disable iff (!rst_n)
        (long_sent_reg & ~held_reg) == '0)
        else $error("long flag set on a key that is not held");

    a_idle_queue_empty: assert property (@(posedge clk) disable iff (!rst_n)
        scan_take |-> !evq_stat.pend_valid)
        else $error("scan taken while an event of the last scan is held back");

    a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH && evq_stat.ready) |=>
            (state_reg == S_IDLE && !evq_stat.pend_valid))
        else $error("flush left an event behind");

    a_pause_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLAMP) |=> (pause_reg >= $past(cfg.min_pause)))
        else $error("repeat pause fell below its floor");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the key matrix event generator core.
module testbench;

    // A scan that makes no event still keeps the block busy while it walks the matrix.
    localparam int WALK_CYCLES = 400;

    // Register code that decodes to no register. A write to it must leave every
    // register unchanged.
    localparam logic [2:0] REG_UNUSED = 3'd6;

    // One key event as it leaves the block: row, column, kind and end-of-scan flag.
    typedef struct packed {
        logic [2:0]           row;
        logic [2:0]           col;
        kmeg_pkg::ev_kind_t   kind;
        logic                 last;
    } key_event_t;

    // The receiver moves among three stall patterns, each chosen at random.
    typedef enum int {RX_OPEN, RX_SPARSE, RX_BURSTY} rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        scan_valid = 1'b0;
    logic        scan_stall;
    logic [31:0] now_ms = '0;
    logic [47:0] pressed_bits = '0;
    logic        event_valid;
    logic        event_stall = 1'b0;
    logic [2:0]  key_row;
    logic [2:0]  key_column;
    logic [1:0]  event_kind;
    logic        last_event;

    // Predictor state: the configuration as last written and the per-key memory.
    kmeg_pkg::cfg_t model_cfg;
    logic [31:0] press_time [48];
    bit          key_is_held [48];
    bit          long_flag [48];
    logic [31:0] repeat_start;
    bit          repeat_running;
    logic [15:0] repeat_gap;

    // Events predicted for accepted scans and not yet seen at the output.
    key_event_t  pending_events [$];
    int          mismatch_count = 0;

    // Sender pacing: bursts of scans separated by random gaps, unless steady.
    int          burst_left = 0;
    bit          steady_sender = 1'b0;
    logic [31:0] clock_ms = '0;

    // Receiver stall pattern.
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_mode_left = 0;
    int          rx_run_left = 0;
    bit          rx_hold = 1'b0;

    key_matrix_event_generator_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .scan_valid   (scan_valid),
        .scan_stall   (scan_stall),
        .now_ms       (now_ms),
        .pressed_bits (pressed_bits),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .key_row      (key_row),
        .key_column   (key_column),
        .event_kind   (event_kind),
        .last_event   (last_event)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The repeat pause shrinks by a factor of 10/11, rounded down, but never
    // below the configured floor.
    function automatic logic [15:0] shrink_pause(input logic [15:0] pause);
        logic [31:0] next;
        next = ({16'd0, pause} * 32'd10) / 32'd11;
        if (next < {16'd0, model_cfg.min_pause})
            next = {16'd0, model_cfg.min_pause};
        return next[15:0];
    endfunction

    // Walks the matrix column by column, row inside column, exactly as the block
    // does, and queues every event that the scan must produce. Only the final
    // event of a scan carries the last flag.
    task automatic predict_scan(input logic [31:0] stamp_ms, input logic [47:0] keys);
        key_event_t  found [$];
        int          idx;
        logic [31:0] held_for;
        logic [31:0] since_repeat;
        logic        down;
        for (int col = 0; col < 8; col++)
        begin
            for (int row = 0; row < 6; row++)
            begin
                idx = row * 8 + col;
                if (!model_cfg.present_mask[idx])
                    continue;
                down = keys[idx];
                if (key_is_held[idx])
                begin
                    // All elapsed times wrap modulo 2^32 and compare strictly.
                    held_for = stamp_ms - press_time[idx];
                    if (held_for <= {16'd0, model_cfg.hold_ms})
                        continue;
                    if (!down)
                    begin
                        key_is_held[idx] = 1'b0;
                        press_time[idx] = '0;
                        // A key that already reported a long press leaves silently.
                        if (!long_flag[idx])
                            found.push_back(key_event_t'{3'(row), 3'(col),
                                                         kmeg_pkg::EV_RELEASE, 1'b0});
                        long_flag[idx] = 1'b0;
                        repeat_running = 1'b0;
                        repeat_start = '0;
                    end
                    else if (model_cfg.repeat_mask[idx] && !long_flag[idx])
                    begin
                        // The first held repeatable key that finds the shared
                        // timer idle restarts it; no repeat on that same scan.
                        if (!repeat_running)
                        begin
                            repeat_running = 1'b1;
                            repeat_start = stamp_ms;
                            repeat_gap = model_cfg.first_pause;
                        end
                        since_repeat = stamp_ms - repeat_start;
                        if (since_repeat > {16'd0, repeat_gap})
                        begin
                            repeat_gap = shrink_pause(repeat_gap);
                            repeat_start = stamp_ms;
                            found.push_back(key_event_t'{3'(row), 3'(col),
                                                         kmeg_pkg::EV_REPEAT, 1'b0});
                        end
                    end
                    else if (held_for > {16'd0, model_cfg.long_ms} && !long_flag[idx])
                    begin
                        found.push_back(key_event_t'{3'(row), 3'(col),
                                                     kmeg_pkg::EV_LONG, 1'b0});
                        long_flag[idx] = 1'b1;
                    end
                end
                else if (down && !long_flag[idx])
                begin
                    key_is_held[idx] = 1'b1;
                    press_time[idx] = stamp_ms;
                    found.push_back(key_event_t'{3'(row), 3'(col),
                                                 kmeg_pkg::EV_PRESS, 1'b0});
                    // Any press stops the shared repeat timer.
                    repeat_running = 1'b0;
                    repeat_start = '0;
                end
            end
        end
        if (found.size() > 0)
            found[found.size() - 1].last = 1'b1;
        foreach (found[i])
            pending_events.push_back(found[i]);
    endtask

    // One APB write: a setup phase, then the access phase, which completes at
    // the edge where pready is seen high. The predictor keeps only the bits that
    // the register holds, and ignores codes that decode to no register.
    task automatic write_register(input logic [2:0] index, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            kmeg_pkg::REG_PRESENT:     model_cfg.present_mask = value[47:0];
            kmeg_pkg::REG_REPEAT:      model_cfg.repeat_mask = value[47:0];
            kmeg_pkg::REG_HOLD:        model_cfg.hold_ms = value[15:0];
            kmeg_pkg::REG_LONG:        model_cfg.long_ms = value[15:0];
            kmeg_pkg::REG_FIRST_PAUSE: model_cfg.first_pause = value[15:0];
            kmeg_pkg::REG_MIN_PAUSE:   model_cfg.min_pause = value[15:0];
            default:                   ;
        endcase
        // Keeps the next write's setup cycle in a later time step.
        @(posedge clk);
    endtask

    // Offers one scan and waits for the transfer. Unless the sender runs steady,
    // a random gap opens whenever the current burst is used up. The predictor
    // runs at the accepting edge, so expectations are always in scan order.
    task automatic send_scan(input logic [31:0] stamp_ms, input logic [47:0] keys);
        int gap;
        if (!steady_sender && burst_left <= 0)
        begin
            gap = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 8);
            scan_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        burst_left--;
        scan_valid <= 1'b1;
        now_ms <= stamp_ms;
        pressed_bits <= keys;
        do
            @(posedge clk);
        while (scan_stall);
        predict_scan(stamp_ms, keys);
    endtask

    // Stops the sender, waits for every predicted event, then lets the block
    // finish walking a scan that may still be in flight without events.
    task automatic settle_block();
        scan_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_events.size() != 0);
        repeat (WALK_CYCLES)
            @(posedge clk);
    endtask

    task automatic log_mismatch(input string what, input bit has_want,
                                input key_event_t want, input key_event_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            if (has_want)
                $display("%0t: %s: expected row %0d col %0d %s last %0d, got row %0d col %0d %s last %0d",
                         $realtime, what, want.row, want.col, want.kind.name(), want.last,
                         got.row, got.col, got.kind.name(), got.last);
            else
                $display("%0t: %s: got row %0d col %0d %s last %0d",
                         $realtime, what, got.row, got.col, got.kind.name(), got.last);
        end
    endtask

    // Every event transfer is checked against the oldest prediction.
    always @(posedge clk)
    begin
        key_event_t got;
        key_event_t want;
        if (rst_n && event_valid && !event_stall)
        begin
            got = key_event_t'{key_row, key_column, kmeg_pkg::ev_kind_t'(event_kind),
                               last_event};
            if (pending_events.size() == 0)
                log_mismatch("event with none expected", 1'b0, got, got);
            else
            begin
                want = pending_events.pop_front();
                if (got.row !== want.row || got.col !== want.col ||
                    got.kind !== want.kind || got.last !== want.last)
                    log_mismatch("event mismatch", 1'b1, want, got);
            end
        end
    end

    // The receiver alternates between never stalling, stalling now and then,
    // and stalling in long runs, so stalls land on every part of a walk.
    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(40, 400);
        end
        else
            rx_mode_left--;
        case (rx_mode)
            RX_OPEN:   event_stall <= 1'b0;
            RX_SPARSE: event_stall <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (rx_run_left == 0)
                begin
                    rx_hold = ~rx_hold;
                    rx_run_left = $urandom_range(1, 12);
                end
                else
                    rx_run_left--;
                event_stall <= rx_hold;
            end
        endcase
    end

    // Reset configuration: press everything at time zero, then release too early,
    // exactly at the hold boundary, just past it, and press everything again.
    task automatic test_press_release();
        send_scan(32'd0, '1);
        send_scan(32'd50, '0);
        send_scan(32'd100, '0);
        send_scan(32'd101, '0);
        send_scan(32'd102, '1);
    endtask

    // Key (0,0) auto-repeats and key (1,1) does not. The repeat pause shrinks
    // from 20 down to its floor of 15 while (1,1) reaches its long press; its
    // release is then silent, and the release stops the repeat timer.
    task automatic test_repeat_and_long();
        settle_block();
        write_register(kmeg_pkg::REG_PRESENT, 64'h0000_FFFF_FFFF_FFFF);
        write_register(kmeg_pkg::REG_REPEAT, 64'h0000_0000_0000_0001);
        write_register(kmeg_pkg::REG_HOLD, 64'd10);
        write_register(kmeg_pkg::REG_LONG, 64'd40);
        write_register(kmeg_pkg::REG_FIRST_PAUSE, 64'd20);
        write_register(kmeg_pkg::REG_MIN_PAUSE, 64'd15);
        send_scan(32'd1000, 48'h000000000201);
        send_scan(32'd1011, 48'h000000000201);
        send_scan(32'd1032, 48'h000000000201);
        send_scan(32'd1051, 48'h000000000201);
        send_scan(32'd1068, 48'h000000000201);
        send_scan(32'd1084, 48'h000000000201);
        send_scan(32'd1090, 48'h000000000001);
        send_scan(32'd1095, 48'h000000000001);
        send_scan(32'd1200, 48'h000000000000);
    endtask

    // A press just before the millisecond counter wraps, then a release after it.
    task automatic test_time_wrap();
        send_scan(32'hFFFF_FFF8, 48'h800000000000);
        send_scan(32'h0000_0002, 48'h000000000000);
        send_scan(32'h0000_0003, 48'h000000000000);
    endtask

    // Extreme settings, with junk above each register's width but the floor's: every key present
    // and repeating, no hold, a one-millisecond first pause and the largest floor.
    // A write to an unused code must change nothing. Then an empty present mask.
    task automatic test_register_extremes();
        settle_block();
        write_register(kmeg_pkg::REG_PRESENT, 64'hFFFF_FFFF_FFFF_FFFF);
        write_register(kmeg_pkg::REG_REPEAT, 64'hA5A5_FFFF_FFFF_FFFF);
        write_register(kmeg_pkg::REG_HOLD, 64'hABCD_0000_0000_0000);
        write_register(kmeg_pkg::REG_LONG, 64'hFFFF_FFFF_FFFF_0000);
        write_register(kmeg_pkg::REG_FIRST_PAUSE, 64'h1234_0000_0000_0001);
        write_register(kmeg_pkg::REG_MIN_PAUSE, 64'h0000_0000_0000_FFFF);
        write_register(REG_UNUSED, 64'h0000_0000_0000_0000);
        send_scan(32'd5, '1);
        send_scan(32'd6, '1);
        send_scan(32'd8, '1);
        send_scan(32'd9, '0);
        settle_block();
        write_register(kmeg_pkg::REG_PRESENT, 64'd0);
        write_register(kmeg_pkg::REG_REPEAT, 64'd0);
        send_scan(32'd10, '1);
    endtask

    // Random traffic in six phases, each under its own configuration. Most scans
    // follow a running key picture with small time steps so that keys are pressed,
    // held, repeated and released; some are noise with random keys and time.
    // The last phase uses the largest timings and long jumps in time.
    task automatic test_random_traffic();
        logic [63:0] draw;
        logic [47:0] keys;
        int          idx;
        int          toggles;
        int          tries;
        int          pick;
        for (int phase = 0; phase < 6; phase++)
        begin
            settle_block();
            steady_sender = (phase == 2);
            draw = {$urandom, $urandom};
            write_register(kmeg_pkg::REG_PRESENT,
                           (phase == 1) ? 64'hFFFF_FFFF_FFFF_FFFF
                                        : (draw | {$urandom, $urandom}));
            write_register(kmeg_pkg::REG_REPEAT, {$urandom, $urandom} & {$urandom, $urandom});
            if (phase == 5)
            begin
                write_register(kmeg_pkg::REG_HOLD, 64'd65535);
                write_register(kmeg_pkg::REG_LONG, 64'd65535);
                write_register(kmeg_pkg::REG_FIRST_PAUSE, 64'd65535);
                write_register(kmeg_pkg::REG_MIN_PAUSE, 64'd1);
            end
            else
            begin
                write_register(kmeg_pkg::REG_HOLD, 64'($urandom_range(0, 120)));
                write_register(kmeg_pkg::REG_LONG, 64'($urandom_range(0, 400)));
                write_register(kmeg_pkg::REG_FIRST_PAUSE, 64'($urandom_range(1, 120)));
                write_register(kmeg_pkg::REG_MIN_PAUSE, 64'($urandom_range(1, 40)));
            end
            keys = '0;
            for (int item = 0; item < 18; item++)
            begin
                // Once, let every event of the scans so far drain before going on.
                if (phase == 3 && item == 9)
                begin
                    scan_valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (pending_events.size() != 0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 12)
                begin
                    draw = {$urandom, $urandom};
                    clock_ms = $urandom;
                    send_scan(clock_ms, draw[47:0]);
                end
                else
                begin
                    if (phase == 5 && $urandom_range(0, 3) == 0)
                        clock_ms += $urandom_range(60000, 140000);
                    else if ($urandom_range(0, 9) == 0)
                        clock_ms += $urandom_range(100, 700);
                    else
                        clock_ms += $urandom_range(1, 60);
                    toggles = (pick < 50) ? 0 : (pick < 90) ? 1 : 2;
                    repeat (toggles)
                    begin
                        // Prefer keys that are present, so the toggle matters.
                        tries = 0;
                        do
                        begin
                            idx = $urandom_range(0, 47);
                            tries++;
                        end
                        while (!model_cfg.present_mask[idx] && tries < 8);
                        keys[idx] = ~keys[idx];
                    end
                    send_scan(clock_ms, keys);
                end
            end
        end
        steady_sender = 1'b0;
    endtask

    initial
    begin
        model_cfg.present_mask = kmeg_pkg::PRESENT_RST;
        model_cfg.repeat_mask = kmeg_pkg::REPEAT_RST;
        model_cfg.hold_ms = kmeg_pkg::HOLD_RST;
        model_cfg.long_ms = kmeg_pkg::LONG_RST;
        model_cfg.first_pause = kmeg_pkg::FIRST_PAUSE_RST;
        model_cfg.min_pause = kmeg_pkg::MIN_PAUSE_RST;
        foreach (press_time[i])
        begin
            press_time[i] = '0;
            key_is_held[i] = 1'b0;
            long_flag[i] = 1'b0;
        end
        repeat_start = '0;
        repeat_running = 1'b0;
        repeat_gap = '0;

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_press_release();
        test_repeat_and_long();
        test_time_wrap();
        test_register_extremes();
        test_random_traffic();

        // Drain, then give a stray event time to show up before judging.
        settle_block();
        if (pending_events.size() != 0)
            mismatch_count += pending_events.size();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Guards against a hang: far beyond the slowest correct run.
    initial
    begin
        #(12 * 1500000);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- key_matrix_event_generator_core.f -----
hw/rtl/kmeg_pkg.sv
hw/rtl/kmeg_cfg.sv
hw/rtl/kmeg_tcmp.sv
hw/rtl/kmeg_evq.sv
hw/rtl/key_matrix_event_generator_core.sv
tb/testbench.sv
